// ----- hdl/tapm_pkg.sv -----
// ----------------------------------------------------------------------------
// tapm_pkg: shared types and constants of the triangle affine point map
// Holds the register map, the vertex register bundle and the side-band
// flags that travel with a point through the pipeline.
// ----------------------------------------------------------------------------
package tapm_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned PORT_BITS      = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_A = 3'd0,
    REG_SRC_B = 3'd1,
    REG_SRC_C = 3'd2,
    REG_DST_A = 3'd3,
    REG_DST_B = 3'd4,
    REG_DST_C = 3'd5
  } tapm_reg_t;

  // Packed vertices: x in bits 31:16, y in bits 15:0.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] src_a;
    logic [CFG_DATA_W-1:0] src_b;
    logic [CFG_DATA_W-1:0] src_c;
    logic [CFG_DATA_W-1:0] dst_a;
    logic [CFG_DATA_W-1:0] dst_b;
    logic [CFG_DATA_W-1:0] dst_c;
  } tapm_cfg_t;

  // Flags that follow a point: quotient signs per lane, zero determinant.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic degen;
  } tapm_side_t;

endpackage

// ----- hdl/tapm_in_if.sv -----
// ----------------------------------------------------------------------------
// tapm_in_if: input point channel
// Carries one source-space point per request with valid/ready.
// ----------------------------------------------------------------------------
interface tapm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ----- hdl/tapm_out_if.sv -----
// ----------------------------------------------------------------------------
// tapm_out_if: mapped point channel
// Carries one destination-space point and its flags per request.
// ----------------------------------------------------------------------------
interface tapm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mapped_x;
  logic [15:0] mapped_y;
  logic        degenerate;
  logic        clipped;

  modport source (output valid, output mapped_x, output mapped_y,
                  output degenerate, output clipped, input ready);
  modport sink   (input valid, input mapped_x, input mapped_y,
                  input degenerate, input clipped, output ready);
endinterface

// ----- hdl/tapm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tapm_cfg_if: configuration write channel
// Carries a register index and write data per request.
// ----------------------------------------------------------------------------
interface tapm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/triangle_affine_point_map.sv -----
// ----------------------------------------------------------------------------
// triangle_affine_point_map: barycentric point map between two triangles
// Maps each source-space point into the destination triangle with exact
// integer weights, a chain of division cells, round-half-away and clamping.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                   Handshake
//  in_pt     in   point_x, point_y                          valid/ready
//  out_pt    out  mapped_x, mapped_y, degenerate, clipped   valid/ready
//  cfg_wr    in   index (0..5 vertex registers), data       valid/ready
//
// One point is accepted per clock while the output is ready or a stage is
// empty. The pipe holds five weight and numerator stages, CW + 3 division
// cells and two rounding stages, CW being COORD_BITS capped at 16. Reset
// clears the vertex registers and all stage valid bits.
// A stalled output only holds the stages that are full, so empty stages ahead
// of it keep taking requests until the whole pipe is full.
// Vertex registers must be written only while the pipe is empty.
//
module triangle_affine_point_map #(
  parameter int unsigned COORD_BITS = tapm_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tapm_in_if.sink    in_pt,
  tapm_out_if.source out_pt,
  tapm_cfg_if.sink   cfg_wr
);
  import tapm_pkg::*;

  // Coordinates live in 16-bit halves, so wider settings act as 16.
  localparam int unsigned CW     = (COORD_BITS > PORT_BITS) ? PORT_BITS : COORD_BITS;
  localparam int unsigned SW     = 3 * CW + 5;
  localparam int unsigned NW     = 2 * CW + 3;
  localparam int unsigned QW     = CW + 3;
  localparam int unsigned NCELL  = QW;
  localparam int unsigned NFRONT = 5;
  localparam int unsigned NST    = NFRONT + NCELL + 2;

  // Vertex registers.
  tapm_cfg_t cfg_r, cfg_nxt;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (tapm_reg_t'(cfg_wr.index))
        REG_SRC_A: cfg_nxt.src_a = cfg_wr.data;
        REG_SRC_B: cfg_nxt.src_b = cfg_wr.data;
        REG_SRC_C: cfg_nxt.src_c = cfg_wr.data;
        REG_DST_A: cfg_nxt.dst_a = cfg_wr.data;
        REG_DST_B: cfg_nxt.dst_b = cfg_wr.data;
        REG_DST_C: cfg_nxt.dst_c = cfg_wr.data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage valid bits. A stage loads when it is empty or its successor moves,
  // which lets bubbles collapse under a stalled output.
  logic [NST-1:0] vld_r, vld_nxt;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_pt.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = (k == 0) ? in_pt.valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_pt.ready  = rdy[0];
  assign out_pt.valid = vld_r[NST-1];

  // Weight and numerator stages.
  logic [SW-1:0] rem_x [NCELL+1];
  logic [SW-1:0] rem_y [NCELL+1];
  logic [QW-1:0] q_x   [NCELL+1];
  logic [QW-1:0] q_y   [NCELL+1];
  logic [NW-1:0] den   [NCELL+1];
  tapm_side_t    side  [NCELL+1];

  tapm_front #(.CW(CW)) u_front (
    .clk   (clk),
    .en    (rdy[NFRONT-1:0]),
    .cfg   (cfg_r),
    .px    (in_pt.point_x[CW-1:0]),
    .py    (in_pt.point_y[CW-1:0]),
    .mag_x (rem_x[0]),
    .mag_y (rem_y[0]),
    .den   (den[0]),
    .side  (side[0])
  );

  assign q_x[0] = '0;
  assign q_y[0] = '0;

  // Division chain: the first cell tests the overflow bit, then one cell
  // per quotient bit from the top down.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    tapm_div_cell #(.CW(CW), .K(NCELL - 1 - i)) u_cell (
      .clk     (clk),
      .en      (rdy[NFRONT+i]),
      .rem_x_i (rem_x[i]),
      .rem_y_i (rem_y[i]),
      .q_x_i   (q_x[i]),
      .q_y_i   (q_y[i]),
      .den_i   (den[i]),
      .side_i  (side[i]),
      .rem_x_o (rem_x[i+1]),
      .rem_y_o (rem_y[i+1]),
      .q_x_o   (q_x[i+1]),
      .q_y_o   (q_y[i+1]),
      .den_o   (den[i+1]),
      .side_o  (side[i+1])
    );
  end

  logic [CW-1:0] mapped_x, mapped_y;

  tapm_finish #(.CW(CW)) u_finish (
    .clk        (clk),
    .en         (rdy[NST-1:NST-2]),
    .cfg        (cfg_r),
    .rem_x      (rem_x[NCELL]),
    .rem_y      (rem_y[NCELL]),
    .q_x        (q_x[NCELL]),
    .q_y        (q_y[NCELL]),
    .den        (den[NCELL]),
    .side       (side[NCELL]),
    .mapped_x   (mapped_x),
    .mapped_y   (mapped_y),
    .degenerate (out_pt.degenerate),
    .clipped    (out_pt.clipped)
  );

  // Narrow coordinates come out zero-extended in the 16-bit fields.
  assign out_pt.mapped_x = PORT_BITS'(mapped_x);
  assign out_pt.mapped_y = PORT_BITS'(mapped_y);

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && out_pt.degenerate) |->
      (out_pt.mapped_x == '0 && out_pt.mapped_y == '0 && !out_pt.clipped))
    else $error("degenerate result carries nonzero data");

  a_full_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pt.ready |-> (&vld_r))
    else $error("input refused while a stage is empty");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> vld_r[0])
    else $error("accepted request did not enter the first stage");
`endif

endmodule

// ----- hdl/tapm_front.sv -----
// ----------------------------------------------------------------------------
// tapm_front: weight and numerator pipeline
// Five stages: products, weight sums, destination products, numerator sums,
// and magnitude/sign split ahead of the divider chain.
// ----------------------------------------------------------------------------
module tapm_front #(
  parameter int unsigned CW = 16
) (
  input  logic                    clk,
  input  logic [4:0]              en,
  input  tapm_pkg::tapm_cfg_t     cfg,
  input  logic signed [CW-1:0]    px,
  input  logic signed [CW-1:0]    py,
  output logic [3*CW+4:0]         mag_x,
  output logic [3*CW+4:0]         mag_y,
  output logic [2*CW+2:0]         den,
  output tapm_pkg::tapm_side_t    side
);
  import tapm_pkg::*;

  localparam int unsigned DW = CW + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned MW = NW + DW;
  localparam int unsigned SW = MW + 1;

  logic signed [CW-1:0] a1x, a1y, b1x, b1y, c1x, c1y;
  logic signed [CW-1:0] a2x, a2y, b2x, b2y, c2x, c2y;

  assign a1x = cfg.src_a[16 +: CW];
  assign a1y = cfg.src_a[0  +: CW];
  assign b1x = cfg.src_b[16 +: CW];
  assign b1y = cfg.src_b[0  +: CW];
  assign c1x = cfg.src_c[16 +: CW];
  assign c1y = cfg.src_c[0  +: CW];
  assign a2x = cfg.dst_a[16 +: CW];
  assign a2y = cfg.dst_a[0  +: CW];
  assign b2x = cfg.dst_b[16 +: CW];
  assign b2y = cfg.dst_b[0  +: CW];
  assign c2x = cfg.dst_c[16 +: CW];
  assign c2y = cfg.dst_c[0  +: CW];

  logic signed [DW-1:0] e_bc_y, e_cb_x, e_ca_y, e_ac_x, e_ac_y, dx, dy;
  logic signed [DW-1:0] g_ac_x, g_bc_x, g_ac_y, g_bc_y;

  assign e_bc_y = DW'(b1y) - DW'(c1y);
  assign e_cb_x = DW'(c1x) - DW'(b1x);
  assign e_ca_y = DW'(c1y) - DW'(a1y);
  assign e_ac_x = DW'(a1x) - DW'(c1x);
  assign e_ac_y = DW'(a1y) - DW'(c1y);
  assign dx     = DW'(px)  - DW'(c1x);
  assign dy     = DW'(py)  - DW'(c1y);
  assign g_ac_x = DW'(a2x) - DW'(c2x);
  assign g_bc_x = DW'(b2x) - DW'(c2x);
  assign g_ac_y = DW'(a2y) - DW'(c2y);
  assign g_bc_y = DW'(b2y) - DW'(c2y);

  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, d1_r, d2_r;
  logic signed [NW-1:0] na_r, nb_r, det1_r, det2_r, det3_r;
  logic signed [MW-1:0] mxa_r, mxb_r, mya_r, myb_r;
  logic signed [SW-1:0] numx_r, numy_r;
  logic [SW-1:0]        mag_x_r, mag_y_r;
  logic [NW-1:0]        den_r;
  tapm_side_t           side_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_r <= e_bc_y * dx;
      p2_r <= e_cb_x * dy;
      p3_r <= e_ca_y * dx;
      p4_r <= e_ac_x * dy;
      d1_r <= e_bc_y * e_ac_x;
      d2_r <= e_cb_x * e_ac_y;
    end
    if (en[1]) begin
      na_r   <= NW'(p1_r) + NW'(p2_r);
      nb_r   <= NW'(p3_r) + NW'(p4_r);
      det1_r <= NW'(d1_r) + NW'(d2_r);
    end
    if (en[2]) begin
      mxa_r  <= na_r * g_ac_x;
      mxb_r  <= nb_r * g_bc_x;
      mya_r  <= na_r * g_ac_y;
      myb_r  <= nb_r * g_bc_y;
      det2_r <= det1_r;
    end
    if (en[3]) begin
      numx_r <= SW'(mxa_r) + SW'(mxb_r);
      numy_r <= SW'(mya_r) + SW'(myb_r);
      det3_r <= det2_r;
    end
    if (en[4]) begin
      mag_x_r      <= numx_r[SW-1] ? unsigned'(-numx_r) : unsigned'(numx_r);
      mag_y_r      <= numy_r[SW-1] ? unsigned'(-numy_r) : unsigned'(numy_r);
      den_r        <= det3_r[NW-1] ? unsigned'(-det3_r) : unsigned'(det3_r);
      side_r.neg_x <= numx_r[SW-1] ^ det3_r[NW-1];
      side_r.neg_y <= numy_r[SW-1] ^ det3_r[NW-1];
      side_r.degen <= (det3_r == '0);
    end
  end

  assign mag_x = mag_x_r;
  assign mag_y = mag_y_r;
  assign den   = den_r;
  assign side  = side_r;

endmodule

// ----- hdl/tapm_div_cell.sv -----
// ----------------------------------------------------------------------------
// tapm_div_cell: one restoring division step for both lanes
// Tries the shifted divisor against the partial remainder, appends the
// quotient bit and hands everything to the next cell.
// ----------------------------------------------------------------------------
module tapm_div_cell #(
  parameter int unsigned CW = 16,
  parameter int unsigned K  = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [3*CW+4:0]       rem_x_i,
  input  logic [3*CW+4:0]       rem_y_i,
  input  logic [CW+2:0]         q_x_i,
  input  logic [CW+2:0]         q_y_i,
  input  logic [2*CW+2:0]       den_i,
  input  tapm_pkg::tapm_side_t  side_i,
  output logic [3*CW+4:0]       rem_x_o,
  output logic [3*CW+4:0]       rem_y_o,
  output logic [CW+2:0]         q_x_o,
  output logic [CW+2:0]         q_y_o,
  output logic [2*CW+2:0]       den_o,
  output tapm_pkg::tapm_side_t  side_o
);
  import tapm_pkg::*;

  localparam int unsigned SW = 3 * CW + 5;
  localparam int unsigned QW = CW + 3;

  logic [SW-1:0] den_sh;
  logic          fit_x, fit_y;
  logic [SW-1:0] rem_x_r, rem_y_r;
  logic [QW-1:0] q_x_r, q_y_r;
  logic [2*CW+2:0] den_r;
  tapm_side_t    side_r;

  assign den_sh = SW'(den_i) << K;
  assign fit_x  = (rem_x_i >= den_sh);
  assign fit_y  = (rem_y_i >= den_sh);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_r <= fit_x ? (rem_x_i - den_sh) : rem_x_i;
      rem_y_r <= fit_y ? (rem_y_i - den_sh) : rem_y_i;
      q_x_r   <= {q_x_i[QW-2:0], fit_x};
      q_y_r   <= {q_y_i[QW-2:0], fit_y};
      den_r   <= den_i;
      side_r  <= side_i;
    end
  end

  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign q_x_o   = q_x_r;
  assign q_y_o   = q_y_r;
  assign den_o   = den_r;
  assign side_o  = side_r;

endmodule

// ----- hdl/tapm_finish.sv -----
// ----------------------------------------------------------------------------
// tapm_finish: floor correction, rounding and saturation
// Two stages: signed quotient plus destination vertex C with rounding
// decisions, then the rounding increment and clamp into the output register.
// ----------------------------------------------------------------------------
module tapm_finish #(
  parameter int unsigned CW = 16
) (
  input  logic                  clk,
  input  logic [1:0]            en,
  input  tapm_pkg::tapm_cfg_t   cfg,
  input  logic [3*CW+4:0]       rem_x,
  input  logic [3*CW+4:0]       rem_y,
  input  logic [CW+2:0]         q_x,
  input  logic [CW+2:0]         q_y,
  input  logic [2*CW+2:0]       den,
  input  tapm_pkg::tapm_side_t  side,
  output logic [CW-1:0]         mapped_x,
  output logic [CW-1:0]         mapped_y,
  output logic                  degenerate,
  output logic                  clipped
);
  import tapm_pkg::*;

  localparam int unsigned NW = 2 * CW + 3;
  localparam int unsigned QB = CW + 2;
  localparam int unsigned QW = QB + 1;
  localparam int unsigned BW = QB + 2;
  localparam logic signed [BW-1:0] CMAX = BW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [BW-1:0] CMIN = -CMAX - BW'(1);

  logic [3*CW+4:0]       rem_l [2];
  logic [QW-1:0]         q_l   [2];
  logic                  neg_l [2];
  logic signed [CW-1:0]  c_l   [2];

  assign rem_l[0] = rem_x;
  assign rem_l[1] = rem_y;
  assign q_l[0]   = q_x;
  assign q_l[1]   = q_y;
  assign neg_l[0] = side.neg_x;
  assign neg_l[1] = side.neg_y;
  assign c_l[0]   = cfg.dst_c[16 +: CW];
  assign c_l[1]   = cfg.dst_c[0  +: CW];

  logic signed [BW-1:0] base0_nxt [2];
  logic                 gt_nxt    [2];
  logic                 eq_nxt    [2];

  always_comb begin
    logic [NW-1:0]        r0;
    logic [NW:0]          tw, dn;
    logic signed [QW-1:0] qs;
    for (int l = 0; l < 2; l++) begin
      r0 = rem_l[l][NW-1:0];
      tw = {r0, 1'b0};
      dn = {1'b0, den};
      if (neg_l[l]) begin
        if (r0 != '0) begin
          // Floor of a negative quotient with remainder den - r0.
          qs        = signed'(~{1'b0, q_l[l][QB-1:0]});
          gt_nxt[l] = (tw < dn);
          eq_nxt[l] = (tw == dn);
        end else begin
          qs        = -signed'({1'b0, q_l[l][QB-1:0]});
          gt_nxt[l] = 1'b0;
          eq_nxt[l] = 1'b0;
        end
      end else begin
        qs        = signed'({1'b0, q_l[l][QB-1:0]});
        gt_nxt[l] = (tw > dn);
        eq_nxt[l] = (tw == dn);
      end
      base0_nxt[l] = BW'(c_l[l]) + BW'(qs);
    end
  end

  logic signed [BW-1:0] base0_r [2];
  logic                 gt_r    [2];
  logic                 eq_r    [2];
  logic                 ovf_r   [2];
  logic                 neg_r   [2];
  logic                 degen_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) begin
        base0_r[l] <= base0_nxt[l];
        gt_r[l]    <= gt_nxt[l];
        eq_r[l]    <= eq_nxt[l];
        ovf_r[l]   <= q_l[l][QB];
        neg_r[l]   <= neg_l[l];
      end
      degen_r <= side.degen;
    end
  end

  logic [CW-1:0] out_nxt  [2];
  logic          clip_nxt [2];

  always_comb begin
    logic signed [BW-1:0] base;
    for (int l = 0; l < 2; l++) begin
      base = base0_r[l] + BW'(gt_r[l] || (eq_r[l] && !base0_r[l][BW-1]));
      if (ovf_r[l]) begin
        out_nxt[l]  = neg_r[l] ? CMIN[CW-1:0] : CMAX[CW-1:0];
        clip_nxt[l] = 1'b1;
      end else if (base > CMAX) begin
        out_nxt[l]  = CMAX[CW-1:0];
        clip_nxt[l] = 1'b1;
      end else if (base < CMIN) begin
        out_nxt[l]  = CMIN[CW-1:0];
        clip_nxt[l] = 1'b1;
      end else begin
        out_nxt[l]  = base[CW-1:0];
        clip_nxt[l] = 1'b0;
      end
    end
  end

  logic [CW-1:0] mx_r, my_r;
  logic          deg_r, clip_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mx_r   <= degen_r ? '0 : out_nxt[0];
      my_r   <= degen_r ? '0 : out_nxt[1];
      deg_r  <= degen_r;
      clip_r <= !degen_r && (clip_nxt[0] || clip_nxt[1]);
    end
  end

  assign mapped_x   = mx_r;
  assign mapped_y   = my_r;
  assign degenerate = deg_r;
  assign clipped    = clip_r;

endmodule
